// ----- rtl/bmf_pkg.sv -----
// Shared types and constants for the BIOP message framer.
// Used by bmf_parser, bmf_rec_queue and biop_message_framer_unit; no dependencies.
package bmf_pkg;

  localparam int OFFSET_BITS   = 32;
  localparam int MAX_KEY_BYTES = 4;
  localparam int QDEPTH        = 4;
  localparam int QPTR_W        = $clog2(QDEPTH);
  localparam int QCNT_W        = $clog2(QDEPTH + 1);

  localparam logic [31:0] BIOP_MAGIC   = 32'h4249_4f50;
  localparam logic [31:0] BIOP_VERSION = 32'h0000_0100;
  localparam logic [31:0] KIND_FILE    = 32'h6669_6c00;
  localparam logic [31:0] KIND_DIR     = 32'h6469_7200;
  localparam logic [31:0] KIND_GATEWAY = 32'h7372_6700;

  typedef logic [OFFSET_BITS-1:0] off_t;

  typedef enum logic [2:0] {
    REC_FILE    = 3'd0,
    REC_DIR     = 3'd1,
    REC_GATEWAY = 3'd2,
    REC_UNKNOWN = 3'd3,
    REC_DONE    = 3'd4,
    REC_ERROR   = 3'd5
  } rec_type_t;

  typedef enum logic [3:0] {
    ERR_NONE      = 4'd0,
    ERR_MAGIC     = 4'd1,
    ERR_VERSION   = 4'd2,
    ERR_ORDER     = 4'd3,
    ERR_TYPE      = 4'd4,
    ERR_KEY_LEN   = 4'd5,
    ERR_KIND_LEN  = 4'd6,
    ERR_TRUNCATED = 4'd7,
    ERR_UNDERFLOW = 4'd8
  } err_code_t;

  typedef struct packed {
    rec_type_t   record_type;
    err_code_t   error_code;
    logic [31:0] object_key;
    logic [31:0] object_key_mask;
    logic [31:0] kind_word;
    logic [31:0] message_start;
    logic [31:0] content_start;
    logic [31:0] content_length;
    logic [15:0] module_tag;
    logic        is_last;
  } rec_t;

  // Records produced by one byte: up to two, rec0 first.
  typedef struct packed {
    logic [1:0] n;
    rec_t       rec0;
    rec_t       rec1;
  } push_t;

endpackage

// ----- rtl/bmf_parser.sv -----
// Byte-serial BIOP header parser: parse state registers and the per-byte next-state logic.
// Depends on bmf_pkg.
module bmf_parser import bmf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,          // byte transfer this cycle
  input  logic [7:0]  data_byte,
  input  logic        end_of_module,
  input  logic [15:0] module_number,
  output push_t       push
);

  typedef enum logic [17:0] {
    PH_MAGIC    = 18'h00001,
    PH_VERSION  = 18'h00002,
    PH_ORDER    = 18'h00004,
    PH_TYPE     = 18'h00008,
    PH_SIZE     = 18'h00010,
    PH_KEYLEN   = 18'h00020,
    PH_KEY      = 18'h00040,
    PH_KINDLEN  = 18'h00080,
    PH_KIND     = 18'h00100,
    PH_INFOLEN  = 18'h00200,
    PH_INFO     = 18'h00400,
    PH_CTXCOUNT = 18'h00800,
    PH_CTXID    = 18'h01000,
    PH_CTXLEN   = 18'h02000,
    PH_CTXDATA  = 18'h04000,
    PH_BODYLEN  = 18'h08000,
    PH_CONTLEN  = 18'h10000,
    PH_SKIP     = 18'h20000
  } phase_t;

  off_t        pos, pos_next;
  phase_t      phase, phase_next;
  logic [31:0] shift, shift_next;
  logic [2:0]  bytes_left, bytes_left_next;
  logic [15:0] skip_count, skip_count_next;
  logic [31:0] body_size, body_size_next;
  logic        size_short, size_short_next;
  logic [2:0]  key_len, key_len_next;
  logic [31:0] key_held, key_held_next;
  logic [31:0] kind_held, kind_held_next;
  logic [7:0]  ctx_left, ctx_left_next;
  off_t        origin, origin_next;
  logic        halted, halted_next;

  function automatic logic [31:0] key_mask(input logic [2:0] len);
    logic [31:0] m;
    case (len)
      3'd1:    m = 32'h0000_00ff;
      3'd2:    m = 32'h0000_ffff;
      3'd3:    m = 32'h00ff_ffff;
      3'd4:    m = 32'hffff_ffff;
      default: m = 32'h0;
    endcase
    return m;
  endfunction

  function automatic rec_t make_rec(input rec_type_t t, input err_code_t e,
                                    input logic [31:0] key, input logic [31:0] mask,
                                    input logic [31:0] kind, input logic [31:0] start,
                                    input logic [31:0] cstart, input logic [31:0] clen,
                                    input logic [15:0] tag);
    rec_t r;
    r.record_type     = t;
    r.error_code      = e;
    r.object_key      = key;
    r.object_key_mask = mask;
    r.kind_word       = kind;
    r.message_start   = start;
    r.content_start   = cstart;
    r.content_length  = clen;
    r.module_tag      = tag;
    r.is_last         = 1'b0;
    return r;
  endfunction

  rec_t        rec_a, rec_e;
  logic        a_valid, e_valid;
  off_t        origin_cur, pos_inc;
  logic [31:0] shift_in;
  logic [7:0]  ctx_dec;
  logic        in_body;

  always_comb begin
    pos_next        = pos;
    phase_next      = phase;
    shift_next      = shift;
    bytes_left_next = bytes_left;
    skip_count_next = skip_count;
    body_size_next  = body_size;
    size_short_next = size_short;
    key_len_next    = key_len;
    key_held_next   = key_held;
    kind_held_next  = kind_held;
    ctx_left_next   = ctx_left;
    origin_next     = origin;
    halted_next     = halted;
    rec_a           = '0;
    rec_e           = '0;
    a_valid         = 1'b0;
    e_valid         = 1'b0;
    pos_inc         = pos + 1'b1;
    origin_cur      = (phase == PH_MAGIC && bytes_left == 3'd4) ? pos : origin;
    shift_in        = {shift[23:0], data_byte};
    ctx_dec         = ctx_left - 8'd1;
    in_body         = !(phase == PH_MAGIC || phase == PH_VERSION || phase == PH_ORDER ||
                        phase == PH_TYPE  || phase == PH_SIZE    || phase == PH_SKIP);

    if (step) begin
      pos_next = pos_inc;
      if (!halted) begin
        if (phase == PH_SKIP) begin
          body_size_next = body_size - 32'd1;
          if (body_size == 32'd1) begin
            phase_next = PH_MAGIC; bytes_left_next = 3'd4; shift_next = '0;
          end
        end else begin
          origin_next = origin_cur;
          if (in_body) begin
            if (body_size != 32'd0) body_size_next = body_size - 32'd1;
            else                    size_short_next = 1'b1;
          end
          if (phase == PH_INFO || phase == PH_CTXDATA) begin
            skip_count_next = skip_count - 16'd1;
            if (skip_count == 16'd1) begin
              shift_next = '0;
              if (phase == PH_INFO) begin
                phase_next = PH_CTXCOUNT; bytes_left_next = 3'd1;
              end else begin
                ctx_left_next   = ctx_dec;
                phase_next      = (ctx_dec != 8'd0) ? PH_CTXID : PH_BODYLEN;
                bytes_left_next = 3'd4;
              end
            end
          end else begin
            shift_next      = shift_in;
            bytes_left_next = bytes_left - 3'd1;
            if (bytes_left == 3'd1) begin
              shift_next = '0;
              unique case (phase)
                PH_MAGIC: begin
                  if (shift_in != BIOP_MAGIC) begin
                    a_valid = 1'b1; halted_next = 1'b1;
                    rec_a = make_rec(REC_ERROR, ERR_MAGIC, '0, '0, '0, 32'(origin_cur),
                                     '0, '0, module_number);
                  end else begin
                    phase_next = PH_VERSION; bytes_left_next = 3'd2;
                  end
                end
                PH_VERSION: begin
                  if (shift_in != BIOP_VERSION) begin
                    a_valid = 1'b1; halted_next = 1'b1;
                    rec_a = make_rec(REC_ERROR, ERR_VERSION, '0, '0, '0, 32'(origin_cur),
                                     '0, '0, module_number);
                  end else begin
                    phase_next = PH_ORDER; bytes_left_next = 3'd1;
                  end
                end
                PH_ORDER: begin
                  if (shift_in != 32'd0) begin
                    a_valid = 1'b1; halted_next = 1'b1;
                    rec_a = make_rec(REC_ERROR, ERR_ORDER, '0, '0, '0, 32'(origin_cur),
                                     '0, '0, module_number);
                  end else begin
                    phase_next = PH_TYPE; bytes_left_next = 3'd1;
                  end
                end
                PH_TYPE: begin
                  if (shift_in != 32'd0) begin
                    a_valid = 1'b1; halted_next = 1'b1;
                    rec_a = make_rec(REC_ERROR, ERR_TYPE, '0, '0, '0, 32'(origin_cur),
                                     '0, '0, module_number);
                  end else begin
                    phase_next = PH_SIZE; bytes_left_next = 3'd4;
                  end
                end
                PH_SIZE: begin
                  body_size_next  = shift_in;
                  size_short_next = 1'b0;
                  phase_next      = PH_KEYLEN;
                  bytes_left_next = 3'd1;
                end
                PH_KEYLEN: begin
                  if (shift_in > 32'(MAX_KEY_BYTES)) begin
                    a_valid = 1'b1; halted_next = 1'b1;
                    rec_a = make_rec(REC_ERROR, ERR_KEY_LEN, '0, '0, '0, 32'(origin_cur),
                                     '0, '0, module_number);
                  end else begin
                    key_len_next  = shift_in[2:0];
                    key_held_next = '0;
                    if (shift_in[2:0] == 3'd0) begin
                      phase_next = PH_KINDLEN; bytes_left_next = 3'd4;
                    end else begin
                      phase_next = PH_KEY; bytes_left_next = shift_in[2:0];
                    end
                  end
                end
                PH_KEY: begin
                  key_held_next   = shift_in;
                  phase_next      = PH_KINDLEN;
                  bytes_left_next = 3'd4;
                end
                PH_KINDLEN: begin
                  if (shift_in != 32'd4) begin
                    a_valid = 1'b1; halted_next = 1'b1;
                    rec_a = make_rec(REC_ERROR, ERR_KIND_LEN, '0, '0, '0, 32'(origin_cur),
                                     '0, '0, module_number);
                  end else begin
                    phase_next = PH_KIND; bytes_left_next = 3'd4;
                  end
                end
                PH_KIND: begin
                  kind_held_next  = shift_in;
                  phase_next      = PH_INFOLEN;
                  bytes_left_next = 3'd2;
                end
                PH_INFOLEN: begin
                  if (size_short_next || body_size_next < shift_in) begin
                    a_valid = 1'b1; halted_next = 1'b1;
                    rec_a = make_rec(REC_ERROR, ERR_UNDERFLOW, '0, '0, '0, 32'(origin_cur),
                                     '0, '0, module_number);
                  end else if (kind_held == KIND_FILE) begin
                    skip_count_next = shift_in[15:0];
                    if (shift_in[15:0] != 16'd0) begin
                      phase_next = PH_INFO;
                    end else begin
                      phase_next = PH_CTXCOUNT; bytes_left_next = 3'd1;
                    end
                  end else begin
                    // non-file kinds: report now, skip the rest of the message
                    if (body_size_next == 32'd0) begin
                      phase_next = PH_MAGIC; bytes_left_next = 3'd4;
                    end else begin
                      phase_next = PH_SKIP;
                    end
                    a_valid = 1'b1;
                    if (kind_held == KIND_DIR)
                      rec_a = make_rec(REC_DIR, ERR_NONE, key_held, key_mask(key_len),
                                       kind_held, 32'(origin_cur), '0, '0, module_number);
                    else if (kind_held == KIND_GATEWAY)
                      rec_a = make_rec(REC_GATEWAY, ERR_NONE, '0, '0, kind_held,
                                       32'(origin_cur), '0, '0, module_number);
                    else
                      rec_a = make_rec(REC_UNKNOWN, ERR_NONE, key_held, key_mask(key_len),
                                       kind_held, 32'(origin_cur), '0, '0, module_number);
                  end
                end
                PH_CTXCOUNT: begin
                  ctx_left_next   = shift_in[7:0];
                  phase_next      = (shift_in[7:0] != 8'd0) ? PH_CTXID : PH_BODYLEN;
                  bytes_left_next = 3'd4;
                end
                PH_CTXID: begin
                  phase_next = PH_CTXLEN; bytes_left_next = 3'd2;
                end
                PH_CTXLEN: begin
                  skip_count_next = shift_in[15:0];
                  if (shift_in[15:0] != 16'd0) begin
                    phase_next = PH_CTXDATA;
                  end else begin
                    ctx_left_next   = ctx_dec;
                    phase_next      = (ctx_dec != 8'd0) ? PH_CTXID : PH_BODYLEN;
                    bytes_left_next = 3'd4;
                  end
                end
                PH_BODYLEN: begin
                  phase_next = PH_CONTLEN; bytes_left_next = 3'd4;
                end
                PH_CONTLEN: begin
                  if (size_short_next) begin
                    a_valid = 1'b1; halted_next = 1'b1;
                    rec_a = make_rec(REC_ERROR, ERR_UNDERFLOW, '0, '0, '0, 32'(origin_cur),
                                     '0, '0, module_number);
                  end else begin
                    if (body_size_next == 32'd0) begin
                      phase_next = PH_MAGIC; bytes_left_next = 3'd4;
                    end else begin
                      phase_next = PH_SKIP;
                    end
                    a_valid = 1'b1;
                    rec_a = make_rec(REC_FILE, ERR_NONE, key_held, key_mask(key_len),
                                     kind_held, 32'(origin_cur), 32'(pos_inc), shift_in,
                                     module_number);
                  end
                end
                default: begin
                  phase_next = PH_MAGIC; bytes_left_next = 3'd4;
                end
              endcase
            end
          end
        end
      end

      if (end_of_module) begin
        if (!halted_next) begin
          e_valid = 1'b1;
          if (phase_next == PH_SKIP || (phase_next == PH_MAGIC && bytes_left_next == 3'd4))
            rec_e = make_rec(REC_DONE, ERR_NONE, '0, '0, '0, '0, '0, '0, module_number);
          else
            rec_e = make_rec(REC_ERROR, ERR_TRUNCATED, '0, '0, '0, 32'(origin_next),
                             '0, '0, module_number);
        end
        // re-arm for the next module
        pos_next        = '0;
        phase_next      = PH_MAGIC;
        bytes_left_next = 3'd4;
        shift_next      = '0;
        skip_count_next = '0;
        body_size_next  = '0;
        size_short_next = 1'b0;
        key_len_next    = '0;
        key_held_next   = '0;
        kind_held_next  = '0;
        ctx_left_next   = '0;
        origin_next     = '0;
        halted_next     = 1'b0;
      end
    end

    push.n    = {1'b0, a_valid} + {1'b0, e_valid};
    push.rec0 = a_valid ? rec_a : rec_e;
    push.rec1 = rec_e;
    push.rec0.is_last = (a_valid ^ e_valid);
    push.rec1.is_last = a_valid & e_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      phase      <= PH_MAGIC;
      shift      <= '0;
      bytes_left <= 3'd4;
      skip_count <= '0;
      body_size  <= '0;
      size_short <= 1'b0;
      key_len    <= '0;
      key_held   <= '0;
      kind_held  <= '0;
      ctx_left   <= '0;
      origin     <= '0;
      halted     <= 1'b0;
    end else begin
      pos        <= pos_next;
      phase      <= phase_next;
      shift      <= shift_next;
      bytes_left <= bytes_left_next;
      skip_count <= skip_count_next;
      body_size  <= body_size_next;
      size_short <= size_short_next;
      key_len    <= key_len_next;
      key_held   <= key_held_next;
      kind_held  <= kind_held_next;
      ctx_left   <= ctx_left_next;
      origin     <= origin_next;
      halted     <= halted_next;
    end
  end

  // a halted parser stays silent
  a_halted_quiet: assert property (@(posedge clk) disable iff (rst)
    step && halted |-> push.n == 2'd0)
    else $error("halted parser produced a record");

  // two records only when a byte also ends the module
  a_pair_at_end: assert property (@(posedge clk) disable iff (rst)
    push.n == 2'd2 |-> step && end_of_module && push.rec1.record_type != REC_FILE)
    else $error("record pair without end of module");

  // after an error the parser is halted unless the module ended
  a_error_halts: assert property (@(posedge clk) disable iff (rst)
    push.n == 2'd1 && push.rec0.record_type == REC_ERROR && !end_of_module |=> halted)
    else $error("error record did not halt the parser");

endmodule

// ----- rtl/bmf_rec_queue.sv -----
// Four-entry record queue between the parser and the result stream; takes two pushes a cycle.
// Depends on bmf_pkg.
module bmf_rec_queue import bmf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  output logic  has_room,   // room for the two records one byte may cause
  output logic  out_valid,
  input  logic  out_ready,
  output rec_t  out_rec
);

  rec_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wptr, rptr;
  logic [QCNT_W-1:0] count;
  logic              pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_rec   = entries[rptr];
  assign has_room  = (count <= QCNT_W'(QDEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) entries[wptr] <= push.rec0;
    if (push.n == 2'd2) entries[wptr + 1'b1] <= push.rec1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + QPTR_W'(push.n);
      rptr  <= rptr + QPTR_W'(pop);
      count <= count + QCNT_W'(push.n) - QCNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.n != 2'd0 |-> (4'(count) + 4'(push.n)) <= 4'(QDEPTH))
    else $error("record queue overflow");

endmodule

// ----- rtl/biop_message_framer_unit.sv -----
// Top level of the BIOP message framer: config register, parser and record queue.
// Depends on bmf_pkg, bmf_parser and bmf_rec_queue.
//
// Throughput: one module byte per cycle while s_axis_tready is high; a byte's records
//   (at most two) enter the queue in its transfer cycle and go out after older records.
// Result stream: one record per ready cycle; s_axis_tready drops while the queue has fewer
//   than two free entries, so a stalled consumer back-pressures the byte stream.
// Reset (rst, synchronous): parser re-armed at offset 0 expecting a magic word,
//   queue emptied, module_number cleared to zero.
module biop_message_framer_unit import bmf_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  // module bytes
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic         s_axis_tlast,   // end_of_module
  // records
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [3:0] error_code, [35:4] object_key, [67:36] object_key_mask,
  // [99:68] kind_word, [131:100] message_start, [163:132] content_start,
  // [195:164] content_length, [211:196] module_tag, [215:212] zero
  output logic [215:0] m_axis_tdata,
  output logic [2:0]   m_axis_tuser,   // [2:0] record_type
  output logic         m_axis_tlast,   // is_last
  // module_number register write
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data
);

  logic [15:0] module_number;
  logic        step;
  logic        has_room;
  push_t       push;
  rec_t        out_rec;

  // config writes must land only while idle, which the block does not enforce; its one write port is always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      module_number <= '0;
    end else if (cfg_valid && cfg_ready) begin
      module_number <= cfg_data;
    end
  end

  // a byte transfer steps the parser
  assign s_axis_tready = has_room;
  assign step          = s_axis_tvalid && s_axis_tready;

  bmf_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .data_byte     (s_axis_tdata),
    .end_of_module (s_axis_tlast),
    .module_number (module_number),
    .push          (push)
  );

  bmf_rec_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .has_room  (has_room),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_rec   (out_rec)
  );

  // pack the record fields, lowest first
  assign m_axis_tuser = out_rec.record_type;
  assign m_axis_tlast = out_rec.is_last;
  assign m_axis_tdata = {4'b0000,
                         out_rec.module_tag,
                         out_rec.content_length,
                         out_rec.content_start,
                         out_rec.message_start,
                         out_rec.kind_word,
                         out_rec.object_key_mask,
                         out_rec.object_key,
                         out_rec.error_code};

endmodule

// ----- tb/bmf_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for biop_message_framer_unit: mirrors the framer byte by byte and
// checks every record that leaves m_axis. Depends on bmf_pkg.
module bmf_checker import bmf_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic         s_axis_tlast,   // end_of_module
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [3:0] error_code, [35:4] object_key, [67:36] object_key_mask,
  // [99:68] kind_word, [131:100] message_start, [163:132] content_start,
  // [195:164] content_length, [211:196] module_tag, [215:212] zero
  input  logic [215:0] m_axis_tdata,
  input  logic [2:0]   m_axis_tuser,   // [2:0] record_type
  input  logic         m_axis_tlast,   // is_last
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [15:0]  cfg_data,
  output int           fail_count,
  output int           pending,
  output int           byte_count,
  output int           rec_count,
  output int           err_count,
  output int           file_count
);

  typedef enum logic [4:0] {
    PH_MAGIC, PH_VERSION, PH_ORDER, PH_TYPE, PH_SIZE, PH_KEYLEN, PH_KEY,
    PH_KINDLEN, PH_KIND, PH_INFOLEN, PH_INFO, PH_CTXCOUNT, PH_CTXID,
    PH_CTXLEN, PH_CTXDATA, PH_BODYLEN, PH_CONTLEN, PH_SKIP
  } phase_t;

  localparam int MAX_PRINTS = 40;

  rec_t        expected_recs[$];
  logic [15:0] mod_num;
  off_t        pos_ctr;
  off_t        origin;
  phase_t      ph;
  logic [31:0] shift_reg;
  logic [31:0] skip_left;
  logic [31:0] body_left;
  logic [31:0] key_v;
  logic [31:0] kind_v;
  logic [2:0]  bytes_left;
  logic [2:0]  klen;
  logic [7:0]  ctx_left;
  bit          short_size;
  bit          halted;

  function automatic void open_field(input phase_t p, input int unsigned n);
    ph = p;
    bytes_left = 3'(n);
    shift_reg = '0;
  endfunction

  function automatic void rearm();
    pos_ctr = '0;
    open_field(PH_MAGIC, 4);
    skip_left = '0;
    body_left = '0;
    short_size = 1'b0;
    klen = '0;
    key_v = '0;
    kind_v = '0;
    ctx_left = '0;
    origin = '0;
    halted = 1'b0;
  endfunction

  function automatic rec_t make_rec(input rec_type_t t, input err_code_t e,
                                    input logic [31:0] key, input logic [31:0] mask,
                                    input logic [31:0] kind, input logic [31:0] start,
                                    input logic [31:0] cstart, input logic [31:0] clen);
    rec_t r;
    r.record_type = t;
    r.error_code = e;
    r.object_key = key;
    r.object_key_mask = mask;
    r.kind_word = kind;
    r.message_start = start;
    r.content_start = cstart;
    r.content_length = clen;
    r.module_tag = mod_num;
    r.is_last = 1'b0;
    return r;
  endfunction

  function automatic logic [31:0] key_bytes_mask();
    if (klen == 3'd0) return '0;
    return 32'hFFFF_FFFF >> (32 - 8 * int'(klen));
  endfunction

  // Rest of the message is skipped byte by byte, or the next header starts.
  function automatic void enter_body();
    if (body_left == 0) open_field(PH_MAGIC, 4);
    else ph = PH_SKIP;
  endfunction

  function automatic void next_context();
    ctx_left = ctx_left - 8'd1;
    if (ctx_left != 0) open_field(PH_CTXID, 4);
    else open_field(PH_BODYLEN, 4);
  endfunction

  function automatic bit halt_with(input err_code_t e, output rec_t r);
    halted = 1'b1;
    r = make_rec(REC_ERROR, e, '0, '0, '0, origin, '0, '0);
    return 1'b1;
  endfunction

  // One byte through the header state machine; at most one record comes out.
  function automatic bit consume(input logic [7:0] b, input off_t pos, output rec_t r);
    logic [31:0] v;
    r = '0;
    if (ph == PH_SKIP) begin
      body_left = body_left - 1;
      if (body_left == 0) open_field(PH_MAGIC, 4);
      return 1'b0;
    end
    if (ph == PH_MAGIC && bytes_left == 3'd4) origin = pos;
    if (ph >= PH_KEYLEN) begin
      if (body_left != 0) body_left = body_left - 1;
      else short_size = 1'b1;
    end
    if (ph == PH_INFO || ph == PH_CTXDATA) begin
      skip_left = skip_left - 1;
      if (skip_left == 0) begin
        if (ph == PH_INFO) open_field(PH_CTXCOUNT, 1);
        else next_context();
      end
      return 1'b0;
    end

    shift_reg = {shift_reg[23:0], b};
    bytes_left = bytes_left - 3'd1;
    if (bytes_left != 0) return 1'b0;
    v = shift_reg;

    case (ph)
      PH_MAGIC: begin
        if (v != BIOP_MAGIC) return halt_with(ERR_MAGIC, r);
        open_field(PH_VERSION, 2);
      end
      PH_VERSION: begin
        if (v != BIOP_VERSION) return halt_with(ERR_VERSION, r);
        open_field(PH_ORDER, 1);
      end
      PH_ORDER: begin
        if (v != 0) return halt_with(ERR_ORDER, r);
        open_field(PH_TYPE, 1);
      end
      PH_TYPE: begin
        if (v != 0) return halt_with(ERR_TYPE, r);
        open_field(PH_SIZE, 4);
      end
      PH_SIZE: begin
        body_left = v;
        short_size = 1'b0;
        open_field(PH_KEYLEN, 1);
      end
      PH_KEYLEN: begin
        if (v > MAX_KEY_BYTES) return halt_with(ERR_KEY_LEN, r);
        klen = v[2:0];
        key_v = '0;
        if (v == 0) open_field(PH_KINDLEN, 4);
        else open_field(PH_KEY, v);
      end
      PH_KEY: begin
        key_v = v;
        open_field(PH_KINDLEN, 4);
      end
      PH_KINDLEN: begin
        if (v != 4) return halt_with(ERR_KIND_LEN, r);
        open_field(PH_KIND, 4);
      end
      PH_KIND: begin
        kind_v = v;
        open_field(PH_INFOLEN, 2);
      end
      PH_INFOLEN: begin
        if (short_size || body_left < v) return halt_with(ERR_UNDERFLOW, r);
        if (kind_v == KIND_FILE) begin
          skip_left = v;
          if (v != 0) ph = PH_INFO;
          else open_field(PH_CTXCOUNT, 1);
          return 1'b0;
        end
        enter_body();
        if (kind_v == KIND_DIR)
          r = make_rec(REC_DIR, ERR_NONE, key_v, key_bytes_mask(), kind_v, origin, '0, '0);
        else if (kind_v == KIND_GATEWAY)
          r = make_rec(REC_GATEWAY, ERR_NONE, '0, '0, kind_v, origin, '0, '0);
        else
          r = make_rec(REC_UNKNOWN, ERR_NONE, key_v, key_bytes_mask(), kind_v, origin,
                       '0, '0);
        return 1'b1;
      end
      PH_CTXCOUNT: begin
        ctx_left = v[7:0];
        if (ctx_left != 0) open_field(PH_CTXID, 4);
        else open_field(PH_BODYLEN, 4);
      end
      PH_CTXID: open_field(PH_CTXLEN, 2);
      PH_CTXLEN: begin
        skip_left = v;
        if (v != 0) ph = PH_CTXDATA;
        else next_context();
      end
      PH_BODYLEN: open_field(PH_CONTLEN, 4);
      PH_CONTLEN: begin
        if (short_size) return halt_with(ERR_UNDERFLOW, r);
        enter_body();
        r = make_rec(REC_FILE, ERR_NONE, key_v, key_bytes_mask(), kind_v, origin,
                     pos + 1, v);
        return 1'b1;
      end
      default: open_field(PH_MAGIC, 4);
    endcase
    return 1'b0;
  endfunction

  task automatic frame_byte(input logic [7:0] b, input logic eom);
    rec_t recs[2];
    rec_t r;
    off_t pos;
    int   n;
    n = 0;
    pos = pos_ctr;
    pos_ctr = pos_ctr + 1;
    if (!halted) begin
      if (consume(b, pos, r)) begin
        recs[n] = r;
        n++;
      end
    end
    if (eom) begin
      if (!halted) begin
        if (ph == PH_SKIP || (ph == PH_MAGIC && bytes_left == 3'd4))
          recs[n] = make_rec(REC_DONE, ERR_NONE, '0, '0, '0, '0, '0, '0);
        else
          recs[n] = make_rec(REC_ERROR, ERR_TRUNCATED, '0, '0, '0, origin, '0, '0);
        n++;
      end
      rearm();
    end
    if (n > 0) recs[n-1].is_last = 1'b1;
    for (int i = 0; i < n; i++) expected_recs.push_back(recs[i]);
  endtask

  task automatic flag(input string what, input logic [31:0] got, input logic [31:0] want);
    if (fail_count < MAX_PRINTS)
      $display("%0t: %s mismatch, got %h want %h", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic check_rec(input rec_t w);
    if (m_axis_tuser != w.record_type) flag("record_type", m_axis_tuser, w.record_type);
    if (m_axis_tdata[3:0] != w.error_code) flag("error_code", m_axis_tdata[3:0], w.error_code);
    if (m_axis_tdata[35:4] != w.object_key) flag("object_key", m_axis_tdata[35:4], w.object_key);
    if (m_axis_tdata[67:36] != w.object_key_mask)
      flag("object_key_mask", m_axis_tdata[67:36], w.object_key_mask);
    if (m_axis_tdata[99:68] != w.kind_word) flag("kind_word", m_axis_tdata[99:68], w.kind_word);
    if (m_axis_tdata[131:100] != w.message_start)
      flag("message_start", m_axis_tdata[131:100], w.message_start);
    if (m_axis_tdata[163:132] != w.content_start)
      flag("content_start", m_axis_tdata[163:132], w.content_start);
    if (m_axis_tdata[195:164] != w.content_length)
      flag("content_length", m_axis_tdata[195:164], w.content_length);
    if (m_axis_tdata[211:196] != w.module_tag)
      flag("module_tag", m_axis_tdata[211:196], w.module_tag);
    if (m_axis_tdata[215:212] != 4'd0) flag("tdata pad", m_axis_tdata[215:212], 32'd0);
    if (m_axis_tlast != w.is_last) flag("is_last", m_axis_tlast, w.is_last);
  endtask

  always @(posedge clk) begin : monitor
    rec_t w;
    if (rst) begin
      expected_recs.delete();
      mod_num = '0;
      rearm();
    end else begin
      if (cfg_valid && cfg_ready) mod_num = cfg_data;
      if (s_axis_tvalid && s_axis_tready) begin
        byte_count++;
        frame_byte(s_axis_tdata, s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        rec_count++;
        if (m_axis_tuser == REC_ERROR) err_count++;
        if (m_axis_tuser == REC_FILE) file_count++;
        if (expected_recs.size() == 0) begin
          flag("unexpected record, type", m_axis_tuser, 32'd0);
        end else begin
          w = expected_recs.pop_front();
          check_rec(w);
        end
      end
    end
    pending = expected_recs.size();
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench top for biop_message_framer_unit: clock, reset, module byte stream,
// record sink and module_number writes. Depends on bmf_pkg, bmf_checker and the RTL.
module tb_top;
  import bmf_pkg::*;

  localparam int RESET_CYCLES  = 5;
  localparam int CYCLE_LIMIT   = 400000;  // far above the slowest legal run
  localparam int PHASE_BYTES   = 250;     // random bytes per register setting
  localparam int N_PHASES      = 5;
  localparam int HOLD_CYCLES   = 400;     // long sink stall, fills the record queue
  localparam int SETTLE_CYCLES = 16;      // extra wait once no predicted record is pending

  // One module byte as it goes on the slave stream.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } mod_byte_t;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;    // [7:0] data_byte
  logic         s_axis_tlast;    // end_of_module
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // [3:0] error_code, [35:4] object_key, [67:36] object_key_mask,
  // [99:68] kind_word, [131:100] message_start, [163:132] content_start,
  // [195:164] content_length, [211:196] module_tag, [215:212] zero
  logic [215:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;    // [2:0] record_type
  logic         m_axis_tlast;    // is_last
  logic         cfg_valid;
  logic         cfg_ready;
  logic [15:0]  cfg_data;

  int fail_count;
  int pending;
  int byte_count;
  int rec_count;
  int err_count;
  int file_count;

  // Shared between the byte driver and the record sink.
  bit idle_on;    // random gaps allowed on both sides
  bit hold_req;   // sink does one long stall, then clears this

  mod_byte_t  stream_q[$];   // bytes waiting to be sent
  logic [7:0] msg[$];        // message under construction

  biop_message_framer_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  bmf_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .byte_count    (byte_count),
    .rec_count     (rec_count),
    .err_count     (err_count),
    .file_count    (file_count)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Message builders. Header layout (big endian):
  //   magic 0-3, version 4-5, order 6, type 7, size 8-11, key length 12,
  //   key, kind length (4), kind (4), info length (2), info,
  //   file only: context count, contexts {id 4, len 2, data}, body len 4,
  //   content len 4, content.
  // size counts every byte after the size field.
  // ---------------------------------------------------------------------------
  function automatic void put_be(input logic [31:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) msg.push_back(v[8*i +: 8]);
  endfunction

  function automatic void put_noise(input int n);
    for (int i = 0; i < n; i++) msg.push_back(8'($urandom));
  endfunction

  function automatic void build_msg(input logic [31:0] kind, input int key_len,
                                    input logic [31:0] key, input int info_len,
                                    input int n_ctx, input int cont_len,
                                    input int tail_len, input int size_adj);
    int ctx_lens[$];
    int kb;
    int size;
    kb = (key_len > MAX_KEY_BYTES) ? MAX_KEY_BYTES : key_len;
    size = 11 + kb + info_len;
    if (kind == KIND_FILE) begin
      size += 9 + cont_len;
      for (int i = 0; i < n_ctx; i++) begin
        ctx_lens.push_back($urandom_range(0, 5));
        size += 6 + ctx_lens[i];
      end
    end else begin
      size += tail_len;
    end
    msg.delete();
    put_be(BIOP_MAGIC, 4);
    put_be(BIOP_VERSION, 2);
    put_be(32'd0, 1);                 // byte order
    put_be(32'd0, 1);                 // message type
    put_be(size + size_adj, 4);
    put_be(key_len, 1);
    put_be(key, kb);
    put_be(32'd4, 4);                 // kind length
    put_be(kind, 4);
    put_be(info_len, 2);
    put_noise(info_len);
    if (kind == KIND_FILE) begin
      put_be(n_ctx, 1);
      foreach (ctx_lens[i]) begin
        put_be($urandom, 4);
        put_be(ctx_lens[i], 2);
        put_noise(ctx_lens[i]);
      end
      put_be($urandom, 4);            // body length, not checked by the framer
      put_be(cont_len, 4);
      put_noise(cont_len);
    end else begin
      put_noise(tail_len);
    end
  endfunction

  // Copy the message into the stream; tlast on its final byte closes the module.
  function automatic void emit_msg(input bit ends_module);
    for (int i = 0; i < msg.size(); i++)
      stream_q.push_back({msg[i], ends_module && (i == msg.size() - 1)});
  endfunction

  // Mostly well-formed messages with random content, some bent or broken.
  function automatic void random_msg();
    logic [31:0] kind;
    int pick;
    int key_len;
    int info_len;
    int cont_len;
    int size_adj;
    pick = $urandom_range(0, 9);
    if (pick < 4)      kind = KIND_FILE;
    else if (pick < 6) kind = KIND_DIR;
    else if (pick < 8) kind = KIND_GATEWAY;
    else               kind = $urandom;
    key_len  = ($urandom_range(0, 29) == 0) ? $urandom_range(5, 255) : $urandom_range(0, 4);
    info_len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
    cont_len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 24);
    size_adj = 0;
    pick = $urandom_range(0, 19);
    if (pick == 0)      size_adj = -$urandom_range(1, 20);   // short size field
    else if (pick == 1) size_adj = $urandom_range(1, 4);     // skip runs into next bytes
    build_msg(kind, key_len, $urandom, info_len, $urandom_range(0, 3), cont_len,
              $urandom_range(0, 12), size_adj);
    pick = $urandom_range(0, 14);
    if (pick == 0) msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom);
    else if (pick == 1) msg[16 + ((key_len > 4) ? 4 : key_len)] = 8'($urandom);  // kind length
  endfunction

  function automatic void random_module();
    int n_msgs;
    int cut;
    if ($urandom_range(0, 19) == 0) begin
      // pure noise
      msg.delete();
      put_noise($urandom_range(1, 24));
      emit_msg(1'b1);
      return;
    end
    n_msgs = $urandom_range(1, 3);
    for (int m = 0; m < n_msgs; m++) begin
      random_msg();
      if (m == n_msgs - 1) begin
        if ($urandom_range(0, 9) == 0) begin
          // module ends early, anywhere in the last message
          cut = $urandom_range(1, msg.size() - 1);
          repeat (cut) void'(msg.pop_back());
        end else if ($urandom_range(0, 9) == 0) begin
          put_noise($urandom_range(1, 8));
        end
      end
      emit_msg(m == n_msgs - 1);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Directed cases, each one module.
  // ---------------------------------------------------------------------------
  function automatic void directed_modules();
    // one-byte modules at both data extremes: truncated in the magic
    msg.delete(); put_be(32'h00, 1); emit_msg(1'b1);
    msg.delete(); put_be(32'hFF, 1); emit_msg(1'b1);
    // directory, empty body: directory and done records on the same byte
    build_msg(KIND_DIR, 0, 32'h0, 0, 0, 0, 0, 0); emit_msg(1'b1);
    // gateway with the widest key, ends inside the skipped body
    build_msg(KIND_GATEWAY, 4, 32'hFFFF_FFFF, 3, 0, 0, 5, 0); emit_msg(1'b1);
    // file with info and two service contexts
    build_msg(KIND_FILE, 2, 32'hA5C3, 2, 2, 3, 0, 0); emit_msg(1'b1);
    // file with no content: file and done records on the last byte
    build_msg(KIND_FILE, 0, 32'h0, 0, 0, 0, 0, 0); emit_msg(1'b1);
    // unknown kind, single key byte
    build_msg(32'hFFFF_FFFF, 1, 32'h5A, 1, 0, 0, 2, 0); emit_msg(1'b1);
    // back-to-back directory and file in one module
    build_msg(KIND_DIR, 3, 32'h123456, 0, 0, 0, 4, 0); emit_msg(1'b0);
    build_msg(KIND_FILE, 4, 32'h0BAD_F00D, 1, 1, 5, 0, 0); emit_msg(1'b1);
    // each header check failing in turn
    build_msg(KIND_DIR, 0, 32'h0, 0, 0, 0, 2, 0); msg[3] = 8'h51; emit_msg(1'b1);
    build_msg(KIND_DIR, 0, 32'h0, 0, 0, 0, 2, 0); msg[5] = 8'h01; emit_msg(1'b1);
    build_msg(KIND_DIR, 0, 32'h0, 0, 0, 0, 2, 0); msg[6] = 8'h01; emit_msg(1'b1);
    build_msg(KIND_DIR, 0, 32'h0, 0, 0, 0, 2, 0); msg[7] = 8'hFF; emit_msg(1'b1);
    build_msg(KIND_DIR, 5, 32'h0, 0, 0, 0, 2, 0); emit_msg(1'b1);
    build_msg(KIND_DIR, 0, 32'h0, 0, 0, 0, 2, 0); msg[16] = 8'h03; emit_msg(1'b1);
    // size too small for the object info
    build_msg(KIND_DIR, 0, 32'h0, 4, 0, 0, 0, -2); emit_msg(1'b1);
    // file whose contexts and length fields run past the message end
    build_msg(KIND_FILE, 0, 32'h0, 0, 1, 0, 0, -8); emit_msg(1'b1);
    // module cut inside the header, then just after a file's context count
    build_msg(KIND_DIR, 2, 32'h0102, 0, 0, 0, 3, 0);
    while (msg.size() > 14) void'(msg.pop_back());
    emit_msg(1'b1);
    build_msg(KIND_FILE, 0, 32'h0, 0, 2, 2, 0, 0);
    while (msg.size() > 24) void'(msg.pop_back());
    emit_msg(1'b1);
    // halted parser ignores a good message that follows
    build_msg(KIND_DIR, 0, 32'h0, 0, 0, 0, 0, 0); msg[0] = 8'h00; emit_msg(1'b0);
    build_msg(KIND_GATEWAY, 0, 32'h0, 0, 0, 0, 1, 0); emit_msg(1'b1);
    // error on the very byte that ends the module
    msg.delete(); put_be(32'h4249_4F51, 4); emit_msg(1'b1);
  endfunction

  // ---------------------------------------------------------------------------
  // Byte driver: one transfer per handshake, random gap bursts when idling is on.
  // Idling switches on and off in runs so that long gap-free stretches occur.
  // ---------------------------------------------------------------------------
  task automatic flush_stream(input bit calm);
    mod_byte_t it;
    int run_left;
    run_left = 0;
    while (stream_q.size() != 0) begin
      if (run_left == 0) begin
        idle_on = !calm && ($urandom_range(0, 3) != 0);
        run_left = $urandom_range(20, 120);
      end
      run_left--;
      it = stream_q.pop_front();
      if (idle_on && $urandom_range(0, 7) == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= it.data;
      s_axis_tlast  <= it.last;
      @(posedge clk);
      while (!s_axis_tready) @(posedge clk);
    end
    s_axis_tvalid <= 1'b0;
  endtask

  // Wait until every predicted record has been seen, plus the queue latency.
  // pending is sampled on the falling edge, away from the checker's update.
  task automatic settle();
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_module_number(input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Record sink: random stall bursts, one long hold on request.
  // ---------------------------------------------------------------------------
  initial begin : record_sink
    int stall_left;
    stall_left = 0;
    m_axis_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
        @(posedge clk);
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        stall_left = $urandom_range(0, 15);
        @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d records outstanding", cycles, pending);
    $display("[biop_message_framer_unit] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence: directed modules at the reset tag, then random phases, each
  // under its own module_number, written only with the framer drained.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [15:0] tag_values[N_PHASES];
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_data      <= '0;
    idle_on  = 1'b1;
    hold_req = 1'b0;
    tag_values = '{16'hFFFF, 16'h0001, 16'($urandom), 16'h8000, 16'h0000};

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    directed_modules();
    flush_stream(1'b0);
    settle();

    for (int p = 0; p < N_PHASES; p++) begin
      write_module_number(tag_values[p]);
      while (stream_q.size() < PHASE_BYTES) random_module();
      // second phase: sink goes quiet while bytes keep coming
      if (p == 1) hold_req = 1'b1;
      // last phase runs with no gaps on either side
      flush_stream(p == N_PHASES - 1);
      settle();
    end

    @(negedge clk);
    $display("Sent %0d module bytes under %0d module_number settings plus reset value.",
             byte_count, N_PHASES);
    $display("Checked %0d records: %0d file, %0d error.", rec_count, file_count, err_count);
    if (fail_count == 0 && pending == 0) begin
      $display("[biop_message_framer_unit] OK");
    end else begin
      $display("%0d mismatches, %0d records outstanding", fail_count, pending);
      $display("[biop_message_framer_unit] ERROR");
    end
    $finish;
  end

endmodule
